/* design/piet_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the sequencer program of the panel event translator.
package piet_pkg;

	localparam int KNOB_COUNT        = 4;
	localparam int BANK_BUTTON_COUNT = 4;
	localparam int KNOB_BITS         = 16;
	localparam int SMOOTH_BITS       = 24;
	localparam int EVENT_SLOTS       = BANK_BUTTON_COUNT + KNOB_COUNT + 3;
	localparam int EVQ_AW            = $clog2(EVENT_SLOTS);
	localparam int CNT_W             = $clog2(EVENT_SLOTS + 1);
	localparam int IDX_W             = $clog2((BANK_BUTTON_COUNT > KNOB_COUNT) ?
		BANK_BUTTON_COUNT : KNOB_COUNT);
	localparam int PROD_W            = SMOOTH_BITS + 16;
	localparam int APB_AW            = 4;

	localparam logic [IDX_W-1:0] BANK_LAST = IDX_W'(BANK_BUTTON_COUNT - 1);
	localparam logic [IDX_W-1:0] KNOB_LAST = IDX_W'(KNOB_COUNT - 1);
	localparam logic [2:0] PLAY_COMBO_INDEX = 3'd4;

	localparam logic [15:0] LONG_PRESS_RST = 16'd700;
	localparam logic [15:0] GAIN_RST       = 16'd13107;
	localparam logic [15:0] THRESHOLD_RST  = 16'd655;
	localparam logic [3:0]  LIMIT_RST      = 4'd11;

	localparam logic [1:0] REG_LONG_PRESS = 2'd0;
	localparam logic [1:0] REG_GAIN       = 2'd1;
	localparam logic [1:0] REG_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_LIMIT      = 2'd3;

	typedef logic [KNOB_COUNT-1:0][KNOB_BITS-1:0] knob_vec_t;

	typedef enum logic [2:0] {
		EV_BANK  = 3'd0,
		EV_COMBO = 3'd1,
		EV_PLAY  = 3'd2,
		EV_TURN  = 3'd3,
		EV_LONG  = 3'd4,
		EV_CLICK = 3'd5,
		EV_KNOB  = 3'd6
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t             kind;
		logic [2:0]           index;
		logic [7:0]           steps;
		logic [KNOB_BITS-1:0] level;
	} ev_t;

	typedef enum logic [3:0] {
		OP_IDLE  = 4'd0,
		OP_START = 4'd1,
		OP_BANK  = 4'd2,
		OP_PLAY  = 4'd3,
		OP_TURN  = 4'd4,
		OP_LONG  = 4'd5,
		OP_CLICK = 4'd6,
		OP_KMUL  = 4'd7,
		OP_KUPD  = 4'd8,
		OP_EMIT  = 4'd9,
		OP_END   = 4'd10
	} uc_op_t;

	typedef enum logic [2:0] {
		C_NEXT      = 3'd0,
		C_ALWAYS    = 3'd1,
		C_WAIT_IN   = 3'd2,
		C_UNPRIMED  = 3'd3,
		C_BANK_MORE = 3'd4,
		C_KNOB_MORE = 3'd5,
		C_EMIT_MORE = 3'd6
	} uc_cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_START = 4'd1;
	localparam step_t ST_BANK  = 4'd2;
	localparam step_t ST_PLAY  = 4'd3;
	localparam step_t ST_TURN  = 4'd4;
	localparam step_t ST_LONG  = 4'd5;
	localparam step_t ST_CLICK = 4'd6;
	localparam step_t ST_KMUL  = 4'd7;
	localparam step_t ST_KUPD  = 4'd8;
	localparam step_t ST_EMIT  = 4'd9;
	localparam step_t ST_END   = 4'd10;

	typedef struct packed {
		uc_op_t   op;
		uc_cond_t cond;
		step_t    target;
	} uc_word_t;

	typedef struct packed {
		logic             prime;
		logic             mul;
		logic             upd;
		logic [IDX_W-1:0] idx;
	} kctl_t;

	typedef struct packed {
		logic                 hit;
		logic [KNOB_BITS-1:0] level;
	} kstat_t;

	// A taken condition jumps to the target, otherwise the program falls through.
	function automatic uc_word_t uc_rom(input step_t step);
		uc_word_t w;
		unique case (step)
			ST_IDLE:  w = '{OP_IDLE,  C_WAIT_IN,   ST_IDLE};
			ST_START: w = '{OP_START, C_UNPRIMED,  ST_END};
			ST_BANK:  w = '{OP_BANK,  C_BANK_MORE, ST_BANK};
			ST_PLAY:  w = '{OP_PLAY,  C_NEXT,      ST_IDLE};
			ST_TURN:  w = '{OP_TURN,  C_NEXT,      ST_IDLE};
			ST_LONG:  w = '{OP_LONG,  C_NEXT,      ST_IDLE};
			ST_CLICK: w = '{OP_CLICK, C_NEXT,      ST_IDLE};
			ST_KMUL:  w = '{OP_KMUL,  C_NEXT,      ST_IDLE};
			ST_KUPD:  w = '{OP_KUPD,  C_KNOB_MORE, ST_KMUL};
			ST_EMIT:  w = '{OP_EMIT,  C_EMIT_MORE, ST_EMIT};
			ST_END:   w = '{OP_END,   C_ALWAYS,    ST_IDLE};
			default:  w = '{OP_IDLE,  C_ALWAYS,    ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* design/piet_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for panel samples and translated events.
interface piet_sample_if;
	import piet_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  shift_held;
	logic                  play_held;
	logic [3:0]            bank_held;
	logic signed [7:0]     encoder_steps;
	logic [KNOB_BITS-1:0]  knob_0;
	logic [KNOB_BITS-1:0]  knob_1;
	logic [KNOB_BITS-1:0]  knob_2;
	logic [KNOB_BITS-1:0]  knob_3;
	logic [31:0]           time_ms;

	modport source (output valid, shift_held, play_held, bank_held, encoder_steps,
		knob_0, knob_1, knob_2, knob_3, time_ms, input ready);
	modport sink (input valid, shift_held, play_held, bank_held, encoder_steps,
		knob_0, knob_1, knob_2, knob_3, time_ms, output ready);
endinterface

interface piet_event_if;
	import piet_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [2:0]            event_kind;
	logic [2:0]            event_index;
	logic signed [7:0]     turn_steps;
	logic [KNOB_BITS-1:0]  knob_level;
	logic                  last_event;

	modport source (output valid, event_kind, event_index, turn_steps, knob_level,
		last_event, input ready);
	modport sink (input valid, event_kind, event_index, turn_steps, knob_level,
		last_event, output ready);
endinterface

/* design/piet_knob_dp.sv */
`timescale 1ns / 1ps
// Knob smoother datapath: shared multiplier, smoothed and reported level stores.
module piet_knob_dp (
	input  logic                clk,
	input  piet_pkg::kctl_t     ctl,
	input  piet_pkg::knob_vec_t knob,
	input  logic [15:0]         gain,
	input  logic [15:0]         thr,
	output piet_pkg::kstat_t    stat
);
	import piet_pkg::*;

	localparam int FRAC_PAD = SMOOTH_BITS - KNOB_BITS;

	logic [SMOOTH_BITS-1:0] smooth_q [KNOB_COUNT];
	logic [SMOOTH_BITS-1:0] rep_q    [KNOB_COUNT];
	logic                   up_s1;
	logic [PROD_W-1:0]      prod_s1;

	logic [SMOOTH_BITS-1:0] x;
	logic [SMOOTH_BITS-1:0] s;
	logic [SMOOTH_BITS-1:0] r;
	logic                   up;
	logic [SMOOTH_BITS-1:0] diff;
	logic [PROD_W-1:0]      rnd;
	logic [SMOOTH_BITS-1:0] mag;
	logic [SMOOTH_BITS-1:0] s_new;
	logic [SMOOTH_BITS-1:0] drift;
	logic                   hit;

	always_comb begin
		x     = {knob[ctl.idx], {FRAC_PAD{1'b0}}};
		s     = smooth_q[ctl.idx];
		r     = rep_q[ctl.idx];
		up    = (x >= s);
		diff  = up ? (x - s) : (s - x);
		rnd   = prod_s1 + PROD_W'(32'h8000);
		mag   = rnd[PROD_W-1:16];
		s_new = up_s1 ? (s + mag) : (s - mag);
		drift = (s_new >= r) ? (s_new - r) : (r - s_new);
		hit   = (drift >= {thr, {(SMOOTH_BITS-16){1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			up_s1   <= up;
			prod_s1 <= PROD_W'(gain) * PROD_W'(diff);
		end
		if (ctl.prime) begin
			for (int k = 0; k < KNOB_COUNT; k++) begin
				smooth_q[k] <= {knob[k], {FRAC_PAD{1'b0}}};
				rep_q[k]    <= {knob[k], {FRAC_PAD{1'b0}}};
			end
		end else if (ctl.upd) begin
			smooth_q[ctl.idx] <= s_new;
			if (hit) begin
				rep_q[ctl.idx] <= s_new;
			end
		end
	end

	assign stat.hit   = hit;
	assign stat.level = s_new[SMOOTH_BITS-1 -: KNOB_BITS];

endmodule

/* design/panel_input_event_translator_top.sv */
`timescale 1ns / 1ps
// Top level of the panel event translator: sequencer, event queue and APB registers.
// The panel channel takes one front-panel sample per transaction; the events channel
// returns zero to eleven event transactions for it, the final one flagged by last_event.
// The very first sample after reset only loads the knob smoothers and button history
// and returns nothing. A microcoded sequencer walks one step per bank button, one each
// for play, turn, long press and click, and two per knob on the shared multiplier, then
// delivers the queued events one per cycle while the receiver is ready. Only one sample
// is in work at a time, while the final event may still sit in the output register.
// When the receiver stalls, the output register holds its event and the sequencer
// waits in its delivery step. Reset clears all history and restores the register
// defaults; the smoother stores need no clearing since the first sample loads them.
// Registers are written through APB at byte address 4*i and read back at the same place.
module panel_input_event_translator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	piet_sample_if.sink                 panel,
	piet_event_if.source                events,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [piet_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import piet_pkg::*;

	typedef struct packed {
		logic        shift;
		logic        play;
		logic [3:0]  bank;
		logic [7:0]  steps;
		knob_vec_t   knob;
		logic [31:0] now;
	} sample_t;

	logic [15:0] long_press_q;
	logic [15:0] gain_q;
	logic [15:0] thr_q;
	logic [3:0]  limit_q;

	sample_t     smp_q;
	step_t       step_q;
	logic [IDX_W-1:0] idx_q;
	logic        primed_q;
	logic        prev_shift_q;
	logic        prev_play_q;
	logic [3:0]  prev_bank_q;
	logic [31:0] press_start_q;
	logic        combo_q;
	logic        long_q;
	ev_t         evq_q [EVENT_SLOTS];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	logic        out_valid_q;
	ev_t         out_q;
	logic        out_last_q;

	uc_word_t    uc;
	logic        taken;
	step_t       step_nxt;
	logic        accept;
	logic        cfg_wr;
	logic [3:0]  cap;
	logic [31:0] held_ms;
	logic        long_ok;
	logic        bank_edge;
	logic        play_edge;
	logic        push_req;
	logic        push_ok;
	ev_t         push_ev;
	logic        emit_fire;
	logic [CNT_W-1:0] cnt_last;
	kctl_t       kctl;
	kstat_t      kstat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_PRESS_RST;
			gain_q       <= GAIN_RST;
			thr_q        <= THRESHOLD_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_LONG_PRESS: long_press_q <= pwdata[15:0];
				REG_GAIN:       gain_q       <= pwdata[15:0];
				REG_THRESHOLD:  thr_q        <= pwdata[15:0];
				REG_LIMIT:      limit_q      <= pwdata[3:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_LONG_PRESS: prdata = {16'd0, long_press_q};
			REG_GAIN:       prdata = {16'd0, gain_q};
			REG_THRESHOLD:  prdata = {16'd0, thr_q};
			REG_LIMIT:      prdata = {28'd0, limit_q};
		endcase
	end

	assign uc           = uc_rom(step_q);
	assign panel.ready  = (uc.op == OP_IDLE);
	assign accept       = panel.valid && panel.ready;

	assign cap       = (limit_q > 4'(EVENT_SLOTS)) ? 4'(EVENT_SLOTS) : limit_q;
	assign held_ms   = smp_q.now - press_start_q;
	assign long_ok   = smp_q.shift && !combo_q && !long_q &&
		(held_ms >= {16'd0, long_press_q});
	assign bank_edge = smp_q.bank[idx_q] && !prev_bank_q[idx_q];
	assign play_edge = smp_q.play && !prev_play_q;
	assign cnt_last  = cnt_q - CNT_W'(1);
	assign emit_fire = (uc.op == OP_EMIT) && (cnt_q != '0) &&
		(!out_valid_q || events.ready);

	assign kctl.prime = (uc.op == OP_START) && !primed_q;
	assign kctl.mul   = (uc.op == OP_KMUL);
	assign kctl.upd   = (uc.op == OP_KUPD);
	assign kctl.idx   = idx_q;

	piet_knob_dp u_knob_dp (
		.clk  (clk),
		.ctl  (kctl),
		.knob (smp_q.knob),
		.gain (gain_q),
		.thr  (thr_q),
		.stat (kstat)
	);

	always_comb begin
		push_req = 1'b0;
		push_ev  = '0;
		unique case (uc.op)
			OP_BANK: begin
				push_req      = bank_edge;
				push_ev.kind  = smp_q.shift ? EV_COMBO : EV_BANK;
				push_ev.index = 3'(idx_q);
			end
			OP_PLAY: begin
				push_req      = play_edge;
				push_ev.kind  = smp_q.shift ? EV_COMBO : EV_PLAY;
				push_ev.index = smp_q.shift ? PLAY_COMBO_INDEX : 3'd0;
			end
			OP_TURN: begin
				push_req      = (smp_q.steps != 8'd0);
				push_ev.kind  = EV_TURN;
				push_ev.steps = smp_q.steps;
			end
			OP_LONG: begin
				push_req      = long_ok;
				push_ev.kind  = EV_LONG;
			end
			OP_CLICK: begin
				push_req      = !smp_q.shift && prev_shift_q && !combo_q && !long_q;
				push_ev.kind  = EV_CLICK;
			end
			OP_KUPD: begin
				push_req      = kstat.hit;
				push_ev.kind  = EV_KNOB;
				push_ev.index = 3'(idx_q);
				push_ev.level = kstat.level;
			end
			default: ;
		endcase
	end

	assign push_ok = push_req && (cnt_q < CNT_W'(cap));

	always_comb begin
		unique case (uc.cond)
			C_NEXT:      taken = 1'b0;
			C_ALWAYS:    taken = 1'b1;
			C_WAIT_IN:   taken = !accept;
			C_UNPRIMED:  taken = !primed_q;
			C_BANK_MORE: taken = (idx_q != BANK_LAST);
			C_KNOB_MORE: taken = (idx_q != KNOB_LAST);
			C_EMIT_MORE: taken = (cnt_q != '0) && !(emit_fire && (rd_q == cnt_last));
			default:     taken = 1'b0;
		endcase
		step_nxt = taken ? uc.target : step_q + step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= ST_IDLE;
			idx_q         <= '0;
			primed_q      <= 1'b0;
			prev_shift_q  <= 1'b0;
			prev_play_q   <= 1'b0;
			prev_bank_q   <= '0;
			press_start_q <= '0;
			combo_q       <= 1'b0;
			long_q        <= 1'b0;
			cnt_q         <= '0;
			rd_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			step_q <= step_nxt;
			unique case (uc.op)
				OP_START: begin
					cnt_q <= '0;
					rd_q  <= '0;
					idx_q <= '0;
					if (!primed_q) begin
						primed_q <= 1'b1;
					end else if (smp_q.shift && !prev_shift_q) begin
						press_start_q <= smp_q.now;
						combo_q       <= 1'b0;
						long_q        <= 1'b0;
					end
				end
				OP_BANK: begin
					idx_q <= taken ? idx_q + IDX_W'(1) : '0;
					if (bank_edge && smp_q.shift) begin
						combo_q <= 1'b1;
					end
				end
				OP_PLAY: begin
					if (play_edge && smp_q.shift) begin
						combo_q <= 1'b1;
					end
				end
				OP_LONG: begin
					if (long_ok) begin
						long_q <= 1'b1;
					end
				end
				OP_CLICK: begin
					if (!smp_q.shift && prev_shift_q) begin
						combo_q <= 1'b0;
						long_q  <= 1'b0;
					end
				end
				OP_KUPD: begin
					idx_q <= taken ? idx_q + IDX_W'(1) : '0;
				end
				OP_END: begin
					prev_shift_q <= smp_q.shift;
					prev_play_q  <= smp_q.play;
					prev_bank_q  <= smp_q.bank;
				end
				default: ;
			endcase
			if (push_ok) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				rd_q        <= rd_q + CNT_W'(1);
			end else if (events.valid && events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q.shift   <= panel.shift_held;
			smp_q.play    <= panel.play_held;
			smp_q.bank    <= panel.bank_held;
			smp_q.steps   <= panel.encoder_steps;
			smp_q.knob[0] <= panel.knob_0;
			smp_q.knob[1] <= panel.knob_1;
			smp_q.knob[2] <= panel.knob_2;
			smp_q.knob[3] <= panel.knob_3;
			smp_q.now     <= panel.time_ms;
		end
		if (push_ok) begin
			evq_q[cnt_q[EVQ_AW-1:0]] <= push_ev;
		end
		if (emit_fire) begin
			out_q      <= evq_q[rd_q[EVQ_AW-1:0]];
			out_last_q <= (rd_q == cnt_last);
		end
	end

	assign events.valid       = out_valid_q;
	assign events.event_kind  = out_q.kind;
	assign events.event_index = out_q.index;
	assign events.turn_steps  = out_q.steps;
	assign events.knob_level  = out_q.level;
	assign events.last_event  = out_last_q;

endmodule

/* design/piet_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the panel event translator and its bind to the top level.
module piet_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_kind,
	input logic [2:0] event_index,
	input logic [7:0] turn_steps,
	input logic [15:0] knob_level,
	input logic       last_event
);
	import piet_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
		$stable({event_kind, event_index, turn_steps, knob_level, last_event}))
		else $error("stalled event transaction changed");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind <= EV_KNOB) && (event_index <= PLAY_COMBO_INDEX))
		else $error("event kind or index out of range");

	a_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((event_kind == EV_TURN) == (turn_steps != 8'd0)))
		else $error("turn steps do not match event kind");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != EV_KNOB) |-> (knob_level == 16'd0))
		else $error("knob level on a non-knob event");

	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample accepted while one is in work");

endmodule

bind panel_input_event_translator_top piet_checker u_piet_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (panel.valid),
	.in_ready    (panel.ready),
	.out_valid   (events.valid),
	.out_ready   (events.ready),
	.event_kind  (events.event_kind),
	.event_index (events.event_index),
	.turn_steps  (events.turn_steps),
	.knob_level  (events.knob_level),
	.last_event  (events.last_event)
);

/* tb/sv/panel_input_event_translator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the panel event translator with an event scoreboard.
module panel_input_event_translator_top_tb;
	import piet_pkg::*;

	typedef struct packed {
		logic                  shift;
		logic                  play;
		logic [3:0]            bank;
		logic [7:0]            steps;
		logic [3:0][15:0]      knob;
		logic [31:0]           tms;
		logic                  drain;
	} panel_sample_t;

	typedef struct packed {
		ev_kind_t    kind;
		logic [2:0]  index;
		logic [7:0]  steps;
		logic [15:0] level;
		logic        last;
	} panel_event_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	piet_sample_if panel();
	piet_event_if  events();

	panel_input_event_translator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.panel   (panel),
		.events  (events),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	panel_sample_t pending_samples[$];
	panel_event_t  expected_events[$];
	panel_sample_t next_sample;
	panel_sample_t seen_sample;
	logic          sample_taken;
	int            send_gap;
	int            stall_left;
	int            hold_left;
	int            hold_requests;
	int            hold_served;
	int            idle_odds;
	int            mismatch_count;

	logic [15:0] cfg_long_press;
	logic [15:0] cfg_gain;
	logic [15:0] cfg_threshold;
	logic [3:0]  cfg_limit;

	logic        seen_first;
	logic        last_shift;
	logic        last_play;
	logic [3:0]  last_bank;
	logic [31:0] shift_press_ms;
	logic        combo_seen;
	logic        long_seen;
	logic [23:0] knob_smooth[4];
	logic [23:0] knob_reported[4];

	logic        gen_shift;
	logic        gen_play;
	logic [3:0]  gen_bank;
	logic [15:0] gen_knob[4];
	logic [31:0] gen_time;

	task automatic translate_sample(input panel_sample_t s);
		panel_event_t evs[$];
		panel_event_t e;
		int           cap;
		int           n;
		logic [23:0]  x;
		logic [23:0]  lv;
		logic [23:0]  drift;
		logic [63:0]  mag;
		logic [31:0]  elapsed;
		cap = (cfg_limit > 4'd11) ? 11 : int'(cfg_limit);
		if (!seen_first) begin
			seen_first = 1'b1;
			last_shift = s.shift;
			last_play = s.play;
			last_bank = s.bank;
			for (int k = 0; k < 4; k++) begin
				knob_smooth[k] = {s.knob[k], 8'h00};
				knob_reported[k] = {s.knob[k], 8'h00};
			end
			return;
		end
		if (s.shift && !last_shift) begin
			shift_press_ms = s.tms;
			combo_seen = 1'b0;
			long_seen = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			if (s.bank[k] && !last_bank[k]) begin
				if (s.shift) begin
					evs.push_back('{EV_COMBO, 3'(k), 8'd0, 16'd0, 1'b0});
					combo_seen = 1'b1;
				end else begin
					evs.push_back('{EV_BANK, 3'(k), 8'd0, 16'd0, 1'b0});
				end
			end
		end
		if (s.play && !last_play) begin
			if (s.shift) begin
				evs.push_back('{EV_COMBO, PLAY_COMBO_INDEX, 8'd0, 16'd0, 1'b0});
				combo_seen = 1'b1;
			end else begin
				evs.push_back('{EV_PLAY, 3'd0, 8'd0, 16'd0, 1'b0});
			end
		end
		if (s.steps != 8'd0)
			evs.push_back('{EV_TURN, 3'd0, s.steps, 16'd0, 1'b0});
		elapsed = s.tms - shift_press_ms;
		if (s.shift && !combo_seen && !long_seen && elapsed >= {16'd0, cfg_long_press}) begin
			evs.push_back('{EV_LONG, 3'd0, 8'd0, 16'd0, 1'b0});
			long_seen = 1'b1;
		end
		if (!s.shift && last_shift) begin
			if (!combo_seen && !long_seen)
				evs.push_back('{EV_CLICK, 3'd0, 8'd0, 16'd0, 1'b0});
			combo_seen = 1'b0;
			long_seen = 1'b0;
		end
		for (int k = 0; k < 4; k++) begin
			x = {s.knob[k], 8'h00};
			lv = knob_smooth[k];
			if (x >= lv) begin
				mag = (64'(cfg_gain) * 64'(x - lv) + 64'h8000) >> 16;
				lv = lv + mag[23:0];
			end else begin
				mag = (64'(cfg_gain) * 64'(lv - x) + 64'h8000) >> 16;
				lv = lv - mag[23:0];
			end
			knob_smooth[k] = lv;
			drift = (lv >= knob_reported[k]) ? lv - knob_reported[k] : knob_reported[k] - lv;
			if (drift >= {cfg_threshold, 8'h00}) begin
				evs.push_back('{EV_KNOB, 3'(k), 8'd0, lv[23:8], 1'b0});
				knob_reported[k] = lv;
			end
		end
		last_shift = s.shift;
		last_play = s.play;
		last_bank = s.bank;
		n = (evs.size() < cap) ? evs.size() : cap;
		for (int i = 0; i < n; i++) begin
			e = evs[i];
			e.last = (i == n - 1);
			expected_events.push_back(e);
		end
	endtask

	task automatic check_event();
		panel_event_t e;
		if (expected_events.size() == 0) begin
			$error("event transaction with nothing expected: kind %0d index %0d",
				events.event_kind, events.event_index);
			mismatch_count++;
			return;
		end
		e = expected_events.pop_front();
		if (events.event_kind !== e.kind) begin
			$error("event_kind: expected %0d, got %0d", e.kind, events.event_kind);
			mismatch_count++;
		end
		if (events.event_index !== e.index) begin
			$error("event_index: expected %0d, got %0d", e.index, events.event_index);
			mismatch_count++;
		end
		if (events.turn_steps !== e.steps) begin
			$error("turn_steps: expected %0d, got %0d", $signed(e.steps), events.turn_steps);
			mismatch_count++;
		end
		if (events.knob_level !== e.level) begin
			$error("knob_level: expected %0d, got %0d", e.level, events.knob_level);
			mismatch_count++;
		end
		if (events.last_event !== e.last) begin
			$error("last_event: expected %0d, got %0d", e.last, events.last_event);
			mismatch_count++;
		end
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] data;
		data = ($urandom & ((idx == REG_LIMIT) ? ~32'hF : ~32'hFFFF)) | value;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LONG_PRESS: cfg_long_press = data[15:0];
			REG_GAIN:       cfg_gain = data[15:0];
			REG_THRESHOLD:  cfg_threshold = data[15:0];
			REG_LIMIT:      cfg_limit = data[3:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int lp, input int gain, input int thr, input int lim);
		write_register(REG_LONG_PRESS, 32'(lp));
		write_register(REG_GAIN, 32'(gain));
		write_register(REG_THRESHOLD, 32'(thr));
		write_register(REG_LIMIT, 32'(lim));
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || panel.valid || expected_events.size() != 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic queue_sample(input logic sh, input logic pl, input logic [3:0] bk,
		input logic [7:0] st, input logic [15:0] k0, input logic [15:0] k1,
		input logic [15:0] k2, input logic [15:0] k3, input logic [31:0] t, input logic drain);
		panel_sample_t s;
		s.shift = sh;
		s.play = pl;
		s.bank = bk;
		s.steps = st;
		s.knob = {k3, k2, k1, k0};
		s.tms = t;
		s.drain = drain;
		pending_samples.push_back(s);
		gen_shift = sh;
		gen_play = pl;
		gen_bank = bk;
		gen_knob[0] = k0;
		gen_knob[1] = k1;
		gen_knob[2] = k2;
		gen_knob[3] = k3;
		gen_time = t;
	endtask

	task automatic queue_random_sample(input logic drain);
		logic [15:0] kv[4];
		logic        sh;
		logic        pl;
		logic [3:0]  bk;
		logic [7:0]  st;
		logic [31:0] t;
		int          v;
		if ($urandom_range(0, 5) == 0) begin
			sh = 1'($urandom_range(0, 1));
			pl = 1'($urandom_range(0, 1));
			bk = 4'($urandom);
			st = 8'($urandom);
			for (int k = 0; k < 4; k++)
				kv[k] = 16'($urandom);
			t = $urandom;
		end else begin
			sh = ($urandom_range(0, 3) == 0) ? !gen_shift : gen_shift;
			pl = ($urandom_range(0, 3) == 0) ? !gen_play : gen_play;
			bk = gen_bank ^ 4'($urandom & $urandom);
			st = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
			for (int k = 0; k < 4; k++) begin
				if ($urandom_range(0, 2) == 0) begin
					kv[k] = 16'($urandom);
				end else begin
					v = int'(gen_knob[k]) + $urandom_range(0, 4000) - 2000;
					kv[k] = (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
				end
			end
			if ($urandom_range(0, 24) == 0)
				t = 32'hFFFF_FFFF - $urandom_range(0, 500);
			else if ($urandom_range(0, 9) == 0)
				t = gen_time + $urandom_range(600, 2000);
			else
				t = gen_time + $urandom_range(0, 300);
		end
		queue_sample(sh, pl, bk, st, kv[0], kv[1], kv[2], kv[3], t, drain);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		if (!panel.valid || sample_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				panel.valid <= 1'b0;
			end else if (pending_samples.size() != 0 &&
				!(pending_samples[0].drain && expected_events.size() != 0)) begin
				next_sample = pending_samples.pop_front();
				panel.shift_held <= next_sample.shift;
				panel.play_held <= next_sample.play;
				panel.bank_held <= next_sample.bank;
				panel.encoder_steps <= next_sample.steps;
				panel.knob_0 <= next_sample.knob[0];
				panel.knob_1 <= next_sample.knob[1];
				panel.knob_2 <= next_sample.knob[2];
				panel.knob_3 <= next_sample.knob[3];
				panel.time_ms <= next_sample.tms;
				panel.valid <= 1'b1;
				if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0)
					send_gap <= $urandom_range(1, 13);
			end else begin
				panel.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= 400;
			events.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			events.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			events.ready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
			stall_left <= $urandom_range(1, 13) - 1;
			events.ready <= 1'b0;
		end else begin
			events.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sample_taken <= (panel.valid === 1'b1) && (panel.ready === 1'b1);
		if (events.valid === 1'b1 && events.ready === 1'b1)
			check_event();
		if (panel.valid === 1'b1 && panel.ready === 1'b1) begin
			seen_sample.shift = panel.shift_held;
			seen_sample.play = panel.play_held;
			seen_sample.bank = panel.bank_held;
			seen_sample.steps = panel.encoder_steps;
			seen_sample.knob = {panel.knob_3, panel.knob_2, panel.knob_1, panel.knob_0};
			seen_sample.tms = panel.time_ms;
			seen_sample.drain = 1'b0;
			translate_sample(seen_sample);
		end
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		panel.valid = 1'b0;
		panel.shift_held = 1'b0;
		panel.play_held = 1'b0;
		panel.bank_held = 4'd0;
		panel.encoder_steps = 8'sd0;
		panel.knob_0 = '0;
		panel.knob_1 = '0;
		panel.knob_2 = '0;
		panel.knob_3 = '0;
		panel.time_ms = 32'd0;
		events.ready = 1'b0;
		sample_taken = 1'b0;
		send_gap = 0;
		stall_left = 0;
		hold_left = 0;
		hold_requests = 0;
		hold_served = 0;
		idle_odds = 3;
		mismatch_count = 0;
		cfg_long_press = LONG_PRESS_RST;
		cfg_gain = GAIN_RST;
		cfg_threshold = THRESHOLD_RST;
		cfg_limit = LIMIT_RST;
		seen_first = 1'b0;
		last_shift = 1'b0;
		last_play = 1'b0;
		last_bank = 4'd0;
		shift_press_ms = 32'd0;
		combo_seen = 1'b0;
		long_seen = 1'b0;
		for (int k = 0; k < 4; k++) begin
			knob_smooth[k] = '0;
			knob_reported[k] = '0;
			gen_knob[k] = '0;
		end
		gen_shift = 1'b0;
		gen_play = 1'b0;
		gen_bank = 4'd0;
		gen_time = 32'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Shift is already down on the priming sample, so the long press counts from zero.
		queue_sample(1, 0, 4'h0, 8'h00, 16'd0, 16'hFFFF, 16'h8000, 16'd1, 32'd100, 0);
		queue_sample(1, 0, 4'h0, 8'h00, 16'd0, 16'hFFFF, 16'h8000, 16'd1, 32'd900, 0);
		queue_sample(0, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd950, 0);
		queue_sample(1, 1, 4'hF, 8'h80, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1000, 0);
		queue_sample(0, 0, 4'h0, 8'h7F, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1100, 0);
		queue_sample(1, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1200, 0);
		queue_sample(0, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1300, 0);
		queue_sample(0, 1, 4'hF, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1400, 0);
		queue_sample(0, 0, 4'h0, 8'h01, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'd1500, 0);
		queue_sample(1, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'hFFFF_FF00, 0);
		queue_sample(1, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'h0000_0200, 0);
		queue_sample(0, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'h0000_0300, 0);
		queue_sample(1, 0, 4'h0, 8'h00, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 32'h0000_0400, 0);
		queue_sample(0, 1, 4'hF, 8'h05, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'h0000_0410, 1);
		queue_sample(0, 1, 4'hF, 8'h00, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'h0000_0420, 0);
		wait_idle();

		idle_odds = 4;
		configure(700, 13107, 655, 11);
		repeat (45) queue_random_sample(0);
		wait_idle();

		idle_odds = 2;
		configure(0, 65535, 0, 15);
		repeat (30) queue_random_sample(0);
		wait_idle();

		idle_odds = 6;
		configure(65535, 0, 65535, 0);
		repeat (20) queue_random_sample(0);
		wait_idle();

		idle_odds = 3;
		configure($urandom_range(50, 900), $urandom_range(0, 65535), $urandom_range(0, 2000),
			$urandom_range(1, 10));
		repeat (45) queue_random_sample(0);
		@(posedge clk);
		hold_requests = hold_requests + 1;
		wait_idle();

		idle_odds = 0;
		configure(700, 13107, 655, 11);
		for (int i = 0; i < 45; i++)
			queue_random_sample(i == 20);
		wait_idle();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
design/piet_pkg.sv
design/piet_if.sv
design/piet_knob_dp.sv
design/panel_input_event_translator_top.sv
design/piet_checker.sv
tb/sv/panel_input_event_translator_top_tb.sv
